>>> hdl/bistatic_cart_to_spherical_core_defines.svh
// ----------------------------------------------------------------------------
// Bistatic converter assertion macros
// Shared concurrent assertion forms for the converter checkers.
// ----------------------------------------------------------------------------
`ifndef BISTATIC_CART_TO_SPHERICAL_CORE_DEFINES_SVH
`define BISTATIC_CART_TO_SPHERICAL_CORE_DEFINES_SVH

// same-cycle implication, reset disabled
`define BCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disabled
`define BCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// Bistatic converter package
// Shared widths, register indexes, angle conventions and the arctangent table.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int COORD_WIDTH_DEF  = 20;
	localparam int MATRIX_WIDTH_DEF = 16;

	localparam int RANGE_W      = 24;
	localparam int ANGLE_W      = 17;
	localparam int CORDIC_STEPS = 30;
	localparam int ACC_W        = 33;
	localparam int NORM_BIT     = 32;
	localparam int ANG_SHIFT    = 16;
	localparam int ANG_ROUND    = 32768;
	localparam int UP_SH        = 4;
	localparam int PLANE_SH     = 8;
	localparam int REG_IDX_W    = 3;

	localparam logic signed [ANGLE_W-1:0] HALF_PI = ANGLE_W'(16384);
	localparam logic signed [ANGLE_W-1:0] FULL_PI = ANGLE_W'(32768);
	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SYSTEM_TYPE,
		REG_HALF_RANGE,
		REG_TX_POSITION,
		REG_RX_POSITION,
		REG_ROT_ROW0,
		REG_ROT_ROW1,
		REG_ROT_ROW2
	} reg_idx_t;

	typedef enum logic [1:0] {
		SYS_XY,
		SYS_ZX,
		SYS_COEL,
		SYS_BEARING
	} sys_type_t;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage

>>> hdl/bcs_if.sv
// ----------------------------------------------------------------------------
// Bistatic converter channels
// Valid/ready channels for target points and converted results.
// ----------------------------------------------------------------------------
interface bcs_in_if
	import bcs_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] target_x;
	logic signed [COORD_WIDTH-1:0] target_y;
	logic signed [COORD_WIDTH-1:0] target_z;

	modport source (output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink (input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

interface bcs_out_if
	import bcs_pkg::*;
();
	logic valid;
	logic ready;
	logic [RANGE_W-1:0] bistatic_range;
	logic signed [ANGLE_W-1:0] azimuth;
	logic signed [ANGLE_W-1:0] elevation;

	modport source (output valid, output bistatic_range, output azimuth,
		output elevation, input ready);
	modport sink (input valid, input bistatic_range, input azimuth,
		input elevation, output ready);
endinterface

>>> hdl/bcs_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root over several lanes, one root bit per stage.
// ----------------------------------------------------------------------------
module bcs_sqrt_pipe #(
	parameter int IN_W   = 62,
	parameter int LANES  = 3,
	parameter int SIDE_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [LANES*IN_W-1:0]    in_rad,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic [LANES*(IN_W/2)-1:0] out_root,
	output logic [SIDE_W-1:0]        out_side
);
	localparam int RT_W = IN_W / 2;

	logic [RT_W-1:0]   vld_q;
	logic [SIDE_W-1:0] side_q [RT_W];
	logic [IN_W-1:0]   rem_q [RT_W][LANES];
	logic [IN_W-1:0]   res_q [RT_W][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[RT_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int k = 1; k < RT_W; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		for (genvar k = 0; k < RT_W; k++) begin : g_bit
			localparam logic [IN_W-1:0] BIT_K = IN_W'(1) << (IN_W - 2 - 2*k);
			logic [IN_W-1:0] rem_in;
			logic [IN_W-1:0] res_in;
			logic [IN_W:0]   trial;
			logic            take;

			if (k == 0) begin : g_first
				assign rem_in = in_rad[l*IN_W +: IN_W];
				assign res_in = '0;
			end else begin : g_next
				assign rem_in = rem_q[k-1][l];
				assign res_in = res_q[k-1][l];
			end

			assign trial = {1'b0, res_in} + {1'b0, BIT_K};
			assign take  = {1'b0, rem_in} >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k][l] <= take ? rem_in - trial[IN_W-1:0] : rem_in;
					res_q[k][l] <= take ? (res_in >> 1) + BIT_K : res_in >> 1;
				end
			end
		end

		assign out_root[l*RT_W +: RT_W] = res_q[RT_W-1][l][RT_W-1:0];
	end

	assign out_valid = vld_q[RT_W-1];
	assign out_side  = side_q[RT_W-1];

endmodule

>>> hdl/bcs_atan_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined four-quadrant arctangent
// Magnitude split, normalizing shift, CORDIC vectoring and quadrant fixup,
// several lanes side by side, angle in units of pi/32768.
// ----------------------------------------------------------------------------
module bcs_atan_pipe
	import bcs_pkg::*;
#(
	parameter int IN_W   = 32,
	parameter int LANES  = 2,
	parameter int SIDE_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [LANES*IN_W-1:0]    in_y,
	input  logic [LANES*IN_W-1:0]    in_x,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic [LANES*ANGLE_W-1:0] out_angle,
	output logic [SIDE_W-1:0]        out_side
);
	localparam int NW       = (IN_W > NORM_BIT + 1) ? IN_W : NORM_BIT + 1;
	localparam int XW       = NW + 3;
	localparam int DEPTH    = CORDIC_STEPS + 3;
	localparam int SH_STEPS = 6;

	typedef struct packed {
		logic zero;
		logic negx;
		logic negy;
		logic yzero;
		logic xzero;
	} quad_t;

	logic [DEPTH-1:0]          vld_q;
	logic [SIDE_W-1:0]         side_q [DEPTH];
	quad_t                     fl_q [DEPTH-1][LANES];
	logic [IN_W-1:0]           my_q [LANES];
	logic [IN_W-1:0]           mx_q [LANES];
	logic [NW-1:0]             ny_q [LANES];
	logic [NW-1:0]             nx_q [LANES];
	logic signed [XW-1:0]      cx_q [CORDIC_STEPS][LANES];
	logic signed [XW-1:0]      cy_q [CORDIC_STEPS][LANES];
	logic signed [ACC_W-1:0]   acc_q [CORDIC_STEPS][LANES];
	logic signed [ANGLE_W-1:0] ang_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int k = 1; k < DEPTH; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [IN_W-1:0] y_in;
		logic signed [IN_W-1:0] x_in;
		logic [NW-1:0]          nrm_y;
		logic [NW-1:0]          nrm_x;

		assign y_in = signed'(in_y[l*IN_W +: IN_W]);
		assign x_in = signed'(in_x[l*IN_W +: IN_W]);

		always_ff @(posedge clk) begin
			if (en) begin
				my_q[l]    <= y_in[IN_W-1] ? -y_in : y_in;
				mx_q[l]    <= x_in[IN_W-1] ? -x_in : x_in;
				fl_q[0][l] <= '{zero: (y_in == '0) && (x_in == '0), negx: x_in[IN_W-1],
					negy: y_in[IN_W-1], yzero: y_in == '0, xzero: x_in == '0};
				for (int k = 1; k < DEPTH - 1; k++) begin
					fl_q[k][l] <= fl_q[k-1][l];
				end
			end
		end

		always_comb begin
			nrm_y = NW'(my_q[l]);
			nrm_x = NW'(mx_q[l]);
			for (int j = 0; j < SH_STEPS; j++) begin
				if (((nrm_y | nrm_x) >> (NORM_BIT + 1 - ((1 << (SH_STEPS - 1)) >> j))) == '0) begin
					nrm_y = nrm_y << ((1 << (SH_STEPS - 1)) >> j);
					nrm_x = nrm_x << ((1 << (SH_STEPS - 1)) >> j);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ny_q[l] <= nrm_y;
				nx_q[l] <= nrm_x;
			end
		end

		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
			logic signed [XW-1:0]    xi;
			logic signed [XW-1:0]    yi;
			logic signed [ACC_W-1:0] ai;
			logic signed [ACC_W-1:0] step;

			if (k == 0) begin : g_first
				assign xi = signed'(XW'(nx_q[l]));
				assign yi = signed'(XW'(ny_q[l]));
				assign ai = '0;
			end else begin : g_next
				assign xi = cx_q[k-1][l];
				assign yi = cy_q[k-1][l];
				assign ai = acc_q[k-1][l];
			end

			assign step = signed'(ACC_W'(ATAN_TAB[k]));

			always_ff @(posedge clk) begin
				if (en) begin
					if (!yi[XW-1]) begin
						cx_q[k][l]  <= xi + (yi >>> k);
						cy_q[k][l]  <= yi - (xi >>> k);
						acc_q[k][l] <= ai + step;
					end else begin
						cx_q[k][l]  <= xi - (yi >>> k);
						cy_q[k][l]  <= yi + (xi >>> k);
						acc_q[k][l] <= ai - step;
					end
				end
			end
		end

		logic signed [ACC_W:0]     rnd;
		logic signed [ACC_W:0]     rsh;
		logic signed [ANGLE_W-1:0] clamp_ang;
		logic signed [ANGLE_W-1:0] q_ang;
		logic signed [ANGLE_W-1:0] a_ang;
		logic signed [ANGLE_W-1:0] f_ang;
		quad_t                     fl;

		always_comb begin
			fl  = fl_q[DEPTH-2][l];
			rnd = (ACC_W+1)'(acc_q[CORDIC_STEPS-1][l]) + (ACC_W+1)'(ANG_ROUND);
			rsh = rnd >>> ANG_SHIFT;
			if (rsh < 0) begin
				clamp_ang = '0;
			end else if (rsh > HALF_PI) begin
				clamp_ang = HALF_PI;
			end else begin
				clamp_ang = ANGLE_W'(rsh);
			end
			if (fl.yzero) begin
				q_ang = '0;
			end else if (fl.xzero) begin
				q_ang = HALF_PI;
			end else begin
				q_ang = clamp_ang;
			end
			a_ang = fl.negx ? FULL_PI - q_ang : q_ang;
			if (fl.zero) begin
				f_ang = '0;
			end else begin
				f_ang = fl.negy ? -a_ang : a_ang;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ang_q[l] <= f_ang;
			end
		end

		assign out_angle[l*ANGLE_W +: ANGLE_W] = ang_q[l];
	end

	assign out_valid = vld_q[DEPTH-1];
	assign out_side  = side_q[DEPTH-1];

endmodule

>>> hdl/bistatic_cart_to_spherical_core.sv
// ----------------------------------------------------------------------------
// Bistatic Cartesian to spherical converter
// Takes one target point per cycle unless the output stalls, and returns
// the bistatic range, azimuth and elevation in the configured angle convention.
// ----------------------------------------------------------------------------
// The core accepts one point every clock and returns one result per point, in
// order. The pipeline has five stages for the offset, rotation and squaring,
// one stage per root bit of the square root unit (COORD_WIDTH + 11), 33 stages
// in the arctangent unit for the magnitude split, normalizing shift, 30 CORDIC
// iterations and the quadrant fixup, and the output register. When the output
// request is not taken the whole pipeline holds and target.ready drops.
// Configuration writes take effect at once; the user must make them while no
// point is in flight, and the block itself does not enforce this.
module bistatic_cart_to_spherical_core
	import bcs_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int MATRIX_WIDTH = MATRIX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bcs_in_if.sink                 target,
	bcs_out_if.source              result,
	input  logic                   cfg_wen,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [3*((COORD_WIDTH > MATRIX_WIDTH) ? COORD_WIDTH : MATRIX_WIDTH)-1:0] cfg_data
);
	localparam int CW     = COORD_WIDTH;
	localparam int MW     = MATRIX_WIDTH;
	localparam int FB     = MW - 2;
	localparam int DW     = CW + 1;
	localparam int PW     = DW + MW;
	localparam int SW     = PW + 2;
	localparam int LW     = CW + 6;
	localparam int QW     = 2 * LW;
	localparam int SQ_W   = QW + 10;
	localparam int RT_W   = SQ_W / 2;
	localparam int UP_W   = LW + UP_SH;
	localparam int AT_W   = LW + 6;
	localparam int SIDE_W = UP_W + 2 * LW;
	localparam int RS_W   = (RT_W + 1 > RANGE_W) ? RT_W + 1 : RANGE_W;
	localparam int PM_W   = 3 * CW;
	localparam int RM_W   = 3 * MW;
	localparam int AS_W   = RANGE_W + $bits(sys_type_t);

	sys_type_t       sys_q;
	logic            half_q;
	logic [PM_W-1:0] tx_q;
	logic [PM_W-1:0] rx_q;
	logic [RM_W-1:0] rot_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q  <= SYS_XY;
			half_q <= 1'b0;
			tx_q   <= '0;
			rx_q   <= '0;
			for (int r = 0; r < 3; r++) begin
				rot_q[r] <= RM_W'(1) << (r * MW + FB);
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SYSTEM_TYPE: sys_q    <= sys_type_t'(cfg_data[$bits(sys_type_t)-1:0]);
				REG_HALF_RANGE:  half_q   <= cfg_data[0];
				REG_TX_POSITION: tx_q     <= cfg_data[PM_W-1:0];
				REG_RX_POSITION: rx_q     <= cfg_data[PM_W-1:0];
				REG_ROT_ROW0:    rot_q[0] <= cfg_data[RM_W-1:0];
				REG_ROT_ROW1:    rot_q[1] <= cfg_data[RM_W-1:0];
				REG_ROT_ROW2:    rot_q[2] <= cfg_data[RM_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic out_vld_q;

	assign en           = !out_vld_q || result.ready;
	assign target.ready = en;

	logic signed [CW-1:0] tgt [3];
	logic signed [CW-1:0] txc [3];
	logic signed [CW-1:0] rxc [3];
	logic signed [MW-1:0] mc [3][3];

	assign tgt[0] = target.target_x;
	assign tgt[1] = target.target_y;
	assign tgt[2] = target.target_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			txc[k] = signed'(tx_q[k*CW +: CW]);
			rxc[k] = signed'(rx_q[k*CW +: CW]);
			for (int c = 0; c < 3; c++) begin
				mc[k][c] = signed'(rot_q[k][c*MW +: MW]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
		end else if (en) begin
			vld_s1    <= target.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
		end
	end

	logic signed [DW-1:0] d1_s1 [3];
	logic signed [DW-1:0] d2_s1 [3];
	logic signed [PW-1:0] p1_s2 [3][3];
	logic signed [PW-1:0] p2_s2 [3][3];
	logic signed [SW-1:0] sum1 [3];
	logic signed [SW-1:0] sum2 [3];
	logic signed [LW-1:0] loc_s3 [3];
	logic signed [LW-1:0] leg_s3 [3];
	logic [QW-1:0]        sql_s4 [3];
	logic [QW-1:0]        sqg_s4 [3];
	logic signed [LW-1:0] loc_s4 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum1[r] = SW'(p1_s2[r][0]) + SW'(p1_s2[r][1]) + SW'(p1_s2[r][2])
				+ (SW'(1) << (FB - 2));
			sum2[r] = SW'(p2_s2[r][0]) + SW'(p2_s2[r][1]) + SW'(p2_s2[r][2])
				+ (SW'(1) << (FB - 2));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d1_s1[k] <= DW'(tgt[k]) - DW'(rxc[k]);
				d2_s1[k] <= DW'(tgt[k]) - DW'(txc[k]);
			end
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p1_s2[r][c] <= PW'(d1_s1[c]) * PW'(mc[r][c]);
					p2_s2[r][c] <= PW'(d2_s1[c]) * PW'(mc[r][c]);
				end
				loc_s3[r] <= LW'(sum1[r] >>> (FB - 1));
				leg_s3[r] <= LW'(sum2[r] >>> (FB - 1));
			end
			for (int k = 0; k < 3; k++) begin
				sql_s4[k] <= QW'(loc_s3[k]) * QW'(loc_s3[k]);
				sqg_s4[k] <= QW'(leg_s3[k]) * QW'(leg_s3[k]);
				loc_s4[k] <= loc_s3[k];
			end
		end
	end

	logic [3*SQ_W-1:0]    rad_s5;
	logic [SIDE_W-1:0]    side_s5;
	logic [SQ_W-1:0]      len_loc;
	logic [SQ_W-1:0]      len_leg;
	logic [SQ_W-1:0]      plane;
	logic signed [UP_W-1:0] up16;
	logic signed [LW-1:0] az_y;
	logic signed [LW-1:0] az_x;

	always_comb begin
		len_loc = SQ_W'(sql_s4[0]) + SQ_W'(sql_s4[1]) + SQ_W'(sql_s4[2]);
		len_leg = SQ_W'(sqg_s4[0]) + SQ_W'(sqg_s4[1]) + SQ_W'(sqg_s4[2]);
		if (sys_q == SYS_ZX) begin
			plane = (SQ_W'(sql_s4[2]) + SQ_W'(sql_s4[0])) << PLANE_SH;
			up16  = UP_W'(loc_s4[1]) << UP_SH;
			az_y  = loc_s4[0];
			az_x  = loc_s4[2];
		end else begin
			plane = (SQ_W'(sql_s4[0]) + SQ_W'(sql_s4[1])) << PLANE_SH;
			up16  = UP_W'(loc_s4[2]) << UP_SH;
			az_y  = loc_s4[1];
			az_x  = loc_s4[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5  <= {plane, len_leg, len_loc};
			side_s5 <= {up16, az_y, az_x};
		end
	end

	logic                sq_vld;
	logic [3*RT_W-1:0]   sq_root;
	logic [SIDE_W-1:0]   sq_side;

	bcs_sqrt_pipe #(
		.IN_W   (SQ_W),
		.LANES  (3),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.in_rad    (rad_s5),
		.in_side   (side_s5),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	logic [RS_W-1:0]        rsum;
	logic [RANGE_W-1:0]     rng;
	logic signed [UP_W-1:0] up_r;
	logic signed [LW-1:0]   azy_r;
	logic signed [LW-1:0]   azx_r;
	logic [2*AT_W-1:0]      at_y;
	logic [2*AT_W-1:0]      at_x;

	always_comb begin
		rsum = RS_W'(sq_root[0 +: RT_W]) + RS_W'(sq_root[RT_W +: RT_W]);
		if (half_q) begin
			rsum = rsum >> 1;
		end
		rng   = (rsum > RS_W'(RANGE_MAX)) ? RANGE_MAX : RANGE_W'(rsum);
		up_r  = signed'(sq_side[2*LW +: UP_W]);
		azy_r = signed'(sq_side[LW +: LW]);
		azx_r = signed'(sq_side[0 +: LW]);
		at_y  = {AT_W'(up_r), AT_W'(azy_r)};
		at_x  = {AT_W'(sq_root[2*RT_W +: RT_W]), AT_W'(azx_r)};
	end

	logic                   at_vld;
	logic [2*ANGLE_W-1:0]   at_ang;
	logic [AS_W-1:0]        at_side;
	sys_type_t              sys_o;
	logic signed [ANGLE_W-1:0] az_o;
	logic signed [ANGLE_W-1:0] el_o;

	bcs_atan_pipe #(
		.IN_W   (AT_W),
		.LANES  (2),
		.SIDE_W (AS_W)
	) u_atan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_vld),
		.in_y      (at_y),
		.in_x      (at_x),
		.in_side   ({rng, sys_q}),
		.out_valid (at_vld),
		.out_angle (at_ang),
		.out_side  (at_side)
	);

	assign sys_o = sys_type_t'(at_side[$bits(sys_type_t)-1:0]);
	assign az_o  = signed'(at_ang[0 +: ANGLE_W]);
	assign el_o  = signed'(at_ang[ANGLE_W +: ANGLE_W]);

	logic [RANGE_W-1:0]        rng_q;
	logic signed [ANGLE_W-1:0] az_q;
	logic signed [ANGLE_W-1:0] el_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= at_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rng_q <= at_side[AS_W-1 -: RANGE_W];
			az_q  <= (sys_o == SYS_BEARING) ? HALF_PI - az_o : az_o;
			el_q  <= (sys_o == SYS_COEL) ? HALF_PI - el_o : el_o;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.bistatic_range = rng_q;
	assign result.azimuth        = az_q;
	assign result.elevation      = el_q;

endmodule

>>> hdl/bcs_checker.sv
// ----------------------------------------------------------------------------
// Bistatic converter port checker
// Watches the converter channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "bistatic_cart_to_spherical_core_defines.svh"

module bcs_checker
	import bcs_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [RANGE_W-1:0]        out_range,
	input logic signed [ANGLE_W-1:0] out_az,
	input logic signed [ANGLE_W-1:0] out_el
);

	`BCS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result request dropped while stalled")
	`BCS_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_range) && $stable(out_az) && $stable(out_el), "result payload changed while stalled")
	`BCS_ASSERT_IMP(a_ready_empty, clk, arst_n, !out_valid, in_ready, "input blocked with empty output")
	`BCS_ASSERT_IMP(a_stall_back, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")

endmodule

bind bistatic_cart_to_spherical_core bcs_checker u_bcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (target.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_range (result.bistatic_range),
	.out_az    (result.azimuth),
	.out_el    (result.elevation)
);
